@@ rtl/core/lruc_pkg.sv @@
package lruc_pkg;

  localparam int TAG_W  = 20;
  localparam int DATA_W = 64;
  localparam int REQ_W  = 3;

  localparam logic [REQ_W-1:0] REQ_READ       = 3'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE      = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FILL_CLEAN = 3'd2;
  localparam logic [REQ_W-1:0] REQ_FILL_DIRTY = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FLUSH      = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [TAG_W-1:0]  tag;
    logic [DATA_W-1:0] block_data;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] block_out;
    logic [TAG_W-1:0]  tag_out;
    logic              item_valid;
    logic              last;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FILL,
    ST_FLUSH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture request
    logic do_lookup;  // compare, update, form result
    logic do_fill;    // evict LRU, install, form result
    logic flush_step; // examine one recency position
    logic flush_none; // form empty flush result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic flush_emit;  // current position holds a dirty block
    logic flush_end;   // current position is the last
    logic flush_more;  // a dirty block sits at a later position
  } sts_t;

endpackage

@@ rtl/core/lruc_datapath.sv @@
module lruc_datapath #(
  parameter int WAYS       = 8,
  parameter int BLOCK_BITS = 64,
  parameter int TAG_BITS   = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  lruc_pkg::req_t      req,
  input  lruc_pkg::cmd_t      cmd,
  output lruc_pkg::sts_t      sts,
  output lruc_pkg::rsp_t      rsp_next
);
  import lruc_pkg::*;

  localparam int WI_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic [TAG_BITS-1:0]   way_tag  [WAYS];
  logic [BLOCK_BITS-1:0] way_data [WAYS];
  logic [WAYS-1:0]       way_valid;
  logic [WAYS-1:0]       way_dirty;
  logic [WI_W-1:0]       order    [WAYS];
  logic [WI_W-1:0]       order_next [WAYS];

  logic [REQ_W-1:0]      r_type;
  logic [TAG_BITS-1:0]   r_tag;
  logic [BLOCK_BITS-1:0] r_data;
  logic [WI_W-1:0]       fpos;

  // Hit search: most recent matching position
  logic            found;
  logic [WI_W-1:0] hpos;
  always_comb begin
    found = 1'b0;
    hpos  = '0;
    for (int p = WAYS - 1; p >= 0; p--) begin
      if (way_valid[order[p]] && way_tag[order[p]] == r_tag) begin
        found = 1'b1;
        hpos  = WI_W'(p);
      end
    end
  end

  logic [WI_W-1:0] mpos;
  logic [WI_W-1:0] hway, vway, fway;
  assign mpos = cmd.do_fill ? WI_W'(WAYS - 1) : hpos;
  assign hway = order[hpos];
  assign vway = order[WAYS-1];
  assign fway = order[fpos];

  // Move-to-front of position mpos
  always_comb begin
    for (int p = 0; p < WAYS; p++) begin
      if (p == 0) order_next[p] = order[mpos];
      else if (WI_W'(p) <= mpos) order_next[p] = order[p-1];
      else order_next[p] = order[p];
    end
  end

  // Dirty block further down the recency order than the walk position
  logic flush_more;
  always_comb begin
    flush_more = 1'b0;
    for (int p = 0; p < WAYS; p++) begin
      if (WI_W'(p) > fpos && way_valid[order[p]] && way_dirty[order[p]]) flush_more = 1'b1;
    end
  end

  assign sts.flush_emit = way_valid[fway] && way_dirty[fway];
  assign sts.flush_end  = (fpos == WI_W'(WAYS - 1));
  assign sts.flush_more = flush_more;

  // Result formation
  always_comb begin
    rsp_next = '0;
    rsp_next.last = 1'b1;
    if (cmd.do_lookup && found) begin
      rsp_next.hit = 1'b1;
      if (r_type == REQ_READ) rsp_next.block_out = DATA_W'(way_data[hway]);
    end else if (cmd.do_fill && way_valid[vway] && way_dirty[vway]) begin
      rsp_next.hit       = 1'b1;
      rsp_next.block_out = DATA_W'(way_data[vway]);
      rsp_next.tag_out   = TAG_W'(way_tag[vway]);
    end else if (cmd.flush_step) begin
      rsp_next.block_out  = DATA_W'(way_data[fway]);
      rsp_next.tag_out    = TAG_W'(way_tag[fway]);
      rsp_next.item_valid = 1'b1;
      rsp_next.last       = !flush_more;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_type <= req.req_type;
      r_tag  <= req.tag[TAG_BITS-1:0];
      r_data <= req.block_data[BLOCK_BITS-1:0];
    end
  end

  // Block contents (no reset)
  always_ff @(posedge clk) begin
    if (cmd.do_lookup && found && r_type == REQ_WRITE) way_data[hway] <= r_data;
    if (cmd.do_fill) way_data[vway] <= r_data;
  end

  // Tags, flags, recency, flush walk
  always_ff @(posedge clk) begin
    if (rst) begin
      way_valid <= '0;
      way_dirty <= '0;
      fpos      <= '0;
      for (int i = 0; i < WAYS; i++) begin
        way_tag[i] <= '0;
        order[i]   <= WI_W'(i);
      end
    end else begin
      if (cmd.load) begin
        fpos <= '0;
      end
      if (cmd.do_lookup && found) begin
        if (r_type == REQ_WRITE) way_dirty[hway] <= 1'b1;
        order <= order_next;
      end
      if (cmd.do_fill) begin
        way_tag[vway]   <= r_tag;
        way_valid[vway] <= 1'b1;
        way_dirty[vway] <= (r_type == REQ_FILL_DIRTY);
        order           <= order_next;
      end
      if (cmd.flush_step || (!cmd.load && !cmd.flush_none && r_type == REQ_FLUSH
                             && !sts.flush_emit && !sts.flush_end)) begin
        fpos <= fpos + 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/lruc_ctrl.sv @@
module lruc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lruc_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  input  lruc_pkg::sts_t sts,
  output lruc_pkg::cmd_t cmd,
  output logic           rsp_load
);
  import lruc_pkg::*;

  state_t state, state_next;
  logic   ov, ov_next;
  logic   slot_free;

  assign out_valid = ov;
  assign slot_free = !ov || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      ov    <= ov_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_ready     = 1'b0;
    rsp_load     = 1'b0;
    ov_next      = ov && !out_ready;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_data.req_type) inside
            REQ_READ, REQ_WRITE:            state_next = ST_LOOKUP;
            REQ_FILL_CLEAN, REQ_FILL_DIRTY: state_next = ST_FILL;
            REQ_FLUSH:                      state_next = ST_FLUSH;
            default:                        state_next = ST_IDLE;
          endcase
        end
      end
      ST_LOOKUP: if (slot_free) begin
        cmd.do_lookup = 1'b1;
        rsp_load = 1'b1;
        ov_next = 1'b1;
        state_next = ST_IDLE;
      end
      ST_FILL: if (slot_free) begin
        cmd.do_fill = 1'b1;
        rsp_load = 1'b1;
        ov_next = 1'b1;
        state_next = ST_IDLE;
      end
      ST_FLUSH: begin
        if (sts.flush_emit) begin
          // Hold the found block until the previous one is taken
          if (slot_free) begin
            cmd.flush_step = 1'b1;
            rsp_load = 1'b1;
            ov_next = 1'b1;
            if (!sts.flush_more) state_next = ST_IDLE;
          end
        end else if (sts.flush_end && slot_free) begin
          // Walk found no dirty block
          cmd.flush_none = 1'b1;
          rsp_load = 1'b1;
          ov_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  property p_no_load_on_busy;
    @(posedge clk) disable iff (rst) rsp_load |-> (!ov || out_ready);
  endproperty
  a_no_load_on_busy: assert property (p_no_load_on_busy) else $error("result overwritten");

  property p_out_hold;
    @(posedge clk) disable iff (rst) (ov && !out_ready) |=> ov;
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result dropped while stalled");

  property p_cmd_onehot;
    @(posedge clk) disable iff (rst) $onehot0(cmd);
  endproperty
  a_cmd_onehot: assert property (p_cmd_onehot) else $error("more than one command");

  property p_ready_idle;
    @(posedge clk) disable iff (rst) in_ready |-> (state == ST_IDLE);
  endproperty
  a_ready_idle: assert property (p_ready_idle) else $error("accept while busy");
`endif

endmodule

@@ rtl/core/lru_write_back_cache_set.sv @@
// One set of a write-back cache with true LRU replacement over WAYS ways. A read or
// write lookup or a clean or dirty fill is accepted in the idle state and compared
// and updated in the lookup or fill state once the output slot is free, which loads
// the registered result. A flush walks the recency order from most recent, one
// position per cycle unless a dirty block waits for the output slot, emitting each
// valid dirty block and setting last on the final one, ending at the last dirty
// block or after all WAYS positions when none is dirty. Requests with unknown codes
// are dropped. A result held by out_ready low stalls the next one.
module lru_write_back_cache_set #(
  parameter int WAYS        = 8,
  parameter int WORD_BYTES  = 4,
  parameter int BLOCK_WORDS = 2,
  parameter int TAG_BITS    = 20
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lruc_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output lruc_pkg::rsp_t out_data
);
  import lruc_pkg::*;

  localparam int BLOCK_BITS = WORD_BYTES * BLOCK_WORDS * 8;

  cmd_t cmd;
  sts_t sts;
  rsp_t rsp_next;
  logic rsp_load;

  lruc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .sts, .cmd, .rsp_load
  );

  lruc_datapath #(
    .WAYS(WAYS), .BLOCK_BITS(BLOCK_BITS), .TAG_BITS(TAG_BITS)
  ) u_dp (
    .clk, .rst, .req(in_data), .cmd, .sts, .rsp_next
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rsp_load) out_data <= rsp_next;
  end

endmodule
